@@ rtl/pipt_pkg.sv @@
`timescale 1ns / 1ps

package pipt_pkg;

    localparam int COORD_BITS    = 16;
    localparam int DIFF_W        = COORD_BITS + 1;
    localparam int PROD_W        = 2 * DIFF_W;
    localparam int COUNT_OUT_W   = 9;
    localparam int MAX_EDGES_DEF = 256;
    localparam int QUEUE_DEPTH   = 4;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]     t_diff;
    typedef logic signed [PROD_W-1:0]     t_prod;

    typedef struct packed {
        t_coord point_x;
        t_coord point_y;
        t_coord edge_start_x;
        t_coord edge_start_y;
        t_coord edge_end_x;
        t_coord edge_end_y;
        logic   last_edge;
    } t_in_word;

    typedef struct packed {
        logic                   inside_res;
        logic [COUNT_OUT_W-1:0] crossing_count;
    } t_out_word;

    typedef struct packed {
        t_diff d_px;
        t_diff d_dy;
        t_diff d_qy;
        t_diff d_ex;
        logic  in_span;
        logic  dy_pos;
        logic  last_edge;
    } t_cls;

    localparam int CLS_W = $bits(t_cls);

endpackage

@@ rtl/pipt_front.sv @@
`timescale 1ns / 1ps

module pipt_front (
    input  pipt_pkg::t_in_word i_word,
    input  logic               i_valid,
    input  logic               i_full,
    output logic               o_stall,
    output logic               o_push,
    output pipt_pkg::t_cls     o_rec
);
    import pipt_pkg::*;

    t_diff w_px;
    t_diff w_py;
    t_diff w_ax;
    t_diff w_ay;
    t_diff w_bx;
    t_diff w_by;
    logic  w_up_span;
    logic  w_dn_span;

    always_comb begin
        w_px = DIFF_W'(i_word.point_x);
        w_py = DIFF_W'(i_word.point_y);
        w_ax = DIFF_W'(i_word.edge_start_x);
        w_ay = DIFF_W'(i_word.edge_start_y);
        w_bx = DIFF_W'(i_word.edge_end_x);
        w_by = DIFF_W'(i_word.edge_end_y);

        w_up_span = (w_py >= w_ay) && (w_py <= w_by);
        w_dn_span = (w_py >= w_by) && (w_py <= w_ay);

        o_rec.d_px      = w_px - w_ax;
        o_rec.d_dy      = w_by - w_ay;
        o_rec.d_qy      = w_py - w_ay;
        o_rec.d_ex      = w_bx - w_ax;
        o_rec.in_span   = (w_ay != w_by) && (w_up_span || w_dn_span);
        o_rec.dy_pos    = w_by > w_ay;
        o_rec.last_edge = i_word.last_edge;
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

endmodule

@@ rtl/pipt_fifo.sv @@
`timescale 1ns / 1ps

module pipt_fifo #(
    parameter int Width = 8,
    parameter int Depth = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [Width-1:0] i_data,
    input  logic             i_pop,
    output logic [Width-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    logic [Width-1:0] r_mem [Depth];
    logic [PtrW-1:0]  r_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr;
    logic [CntW-1:0]  r_count;

    assign o_full  = r_count == CntW'(Depth);
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ rtl/pipt_back.sv @@
`timescale 1ns / 1ps

module pipt_back #(
    parameter int MaxEdges = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pipt_pkg::t_cls      i_rec,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output pipt_pkg::t_out_word o_word
);
    import pipt_pkg::*;

    localparam int CntW = $clog2(MaxEdges + 1);
    localparam int ExtW = (CntW > COUNT_OUT_W) ? CntW : COUNT_OUT_W;

    logic            w_adv;
    logic            w_hit;
    logic            w_par;
    logic [CntW-1:0] w_cnt;
    logic [ExtW-1:0] w_cnt_ext;

    logic            r_s1_vld;
    t_prod           r_p1;
    t_prod           r_p2;
    logic            r_in_span;
    logic            r_dy_pos;
    logic            r_last;
    logic            r_par;
    logic [CntW-1:0] r_cnt;
    logic            r_out_vld;
    t_out_word       r_out;

    assign w_adv = !(r_out_vld && i_stall);
    assign o_pop = w_adv && !i_empty;

    always_comb begin
        w_hit     = r_in_span && (r_dy_pos ? (r_p1 <= r_p2) : (r_p1 >= r_p2));
        w_par     = r_par ^ w_hit;
        w_cnt     = (w_hit && (r_cnt != CntW'(MaxEdges))) ? r_cnt + 1'b1 : r_cnt;
        w_cnt_ext = ExtW'(w_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p1      <= i_rec.d_px * i_rec.d_dy;
            r_p2      <= i_rec.d_qy * i_rec.d_ex;
            r_in_span <= i_rec.in_span;
            r_dy_pos  <= i_rec.dy_pos;
            r_last    <= i_rec.last_edge;
        end
        if (w_adv && r_s1_vld && r_last) begin
            r_out.inside_res     <= w_par;
            r_out.crossing_count <= w_cnt_ext[COUNT_OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_par     <= 1'b0;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld <= !i_empty;
            if (r_s1_vld) begin
                if (r_last) begin
                    r_par     <= 1'b0;
                    r_cnt     <= '0;
                    r_out_vld <= 1'b1;
                end else begin
                    r_par     <= w_par;
                    r_cnt     <= w_cnt;
                    r_out_vld <= 1'b0;
                end
            end else begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_vld;
    assign o_word  = r_out;

endmodule

@@ rtl/polygon_point_inclusion_test_unit.sv @@
`timescale 1ns / 1ps
// channel | valid       | stall       | word
// in      | i_in_valid  | o_in_stall  | i_in_word  (query point, one edge, last flag)
// out     | o_out_valid | i_out_stall | o_out_word (inside parity, crossing count)
// One edge accepted per cycle; the four-entry queue stalls input only when full.
// A result becomes valid once its last edge has passed the queue write, the
// product register and the accumulate/output register, in that order.
// Reset is synchronous, active low; it empties the queue and clears the totals.
// Output stall, while a result is held, halts the multiply and accumulate stages; the queue keeps filling.

module polygon_point_inclusion_test_unit #(
    parameter int MaxEdges = pipt_pkg::MAX_EDGES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pipt_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pipt_pkg::t_out_word o_out_word
);
    import pipt_pkg::*;

    logic             w_push;
    logic             w_pop;
    logic             w_full;
    logic             w_empty;
    t_cls             w_rec_in;
    t_cls             w_rec_out;
    logic [CLS_W-1:0] w_q_out;

    pipt_front u_front (
        .i_word  (i_in_word),
        .i_valid (i_in_valid),
        .i_full  (w_full),
        .o_stall (o_in_stall),
        .o_push  (w_push),
        .o_rec   (w_rec_in)
    );

    pipt_fifo #(
        .Width (CLS_W),
        .Depth (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_rec_in),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    assign w_rec_out = t_cls'(w_q_out);

    pipt_back #(
        .MaxEdges (MaxEdges)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (w_rec_out),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_word  (o_out_word)
    );

endmodule
